// ===== hw/rtl/duty_standby_pump_rotation_top_assert.svh =====
// Assertion macros for the duty/standby pump rotation controller
`ifndef DUTY_STANDBY_PUMP_ROTATION_TOP_ASSERT_SVH
`define DUTY_STANDBY_PUMP_ROTATION_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define DSPR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dspr assertion failed");
`define DSPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dspr assertion failed");
`else
`define DSPR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DSPR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/dspr_pkg.sv =====
// Types and constants of the duty/standby pump rotation controller
`timescale 1ns / 1ps

package dspr_pkg;

    localparam int PUMPS     = 8;
    localparam int PIDX_W    = $clog2(PUMPS);
    localparam int CNT_W     = $clog2(PUMPS + 1);
    localparam int RUN_W     = 40;
    localparam int ELAPSED_W = 16;
    localparam int MASK_W    = 8;
    localparam int OP_W      = 3;
    localparam int SEL_W     = 3;
    localparam int ACT_W     = 4;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 8;
    localparam int CFG_IDX_W  = 1;

    localparam logic [ACT_W-1:0] NONE_CODE = ACT_W'(8);
    localparam logic [RUN_W-1:0] RUN_MAX   = {RUN_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 3'd0,
        OP_START  = 3'd1,
        OP_STOP   = 3'd2,
        OP_FRESET = 3'd3,
        OP_FAULT  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        PS_STOPPED = 2'd0,
        PS_RUNNING = 2'd1,
        PS_FAULTED = 2'd2
    } t_pstate;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_MODE  = 1'b0,
        CFG_WORK_MASK = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_TICK,
        FS_SCAN,
        FS_PICK,
        FS_FIN
    } t_fsm;

endpackage

// ===== hw/rtl/duty_standby_pump_rotation_top.sv =====
// Duty/standby pump rotation controller: top level
// Input stream: one operation per transaction. tuser carries the operation
// (tick, start, stop, fault reset, pump fault); tdata carries elapsed_ms and
// pump_index. Output stream: one result per input transaction with the active
// pump, its state, the station failure flag and the start failure flag.
// Configuration channel writes rotation_mode (index 0) and working_mask
// (index 1); it is always ready.
// Run times live in a registered-read RAM of PUMPS x 40 bits with one valid
// bit per entry, so reset needs no clearing pass; pump states are flops.
// A start in hours mode walks the RAM one entry per cycle to find the pump with
// the least run time.
// One operation is in flight at a time; input ready is high only when idle.
// A finished result sits in the output register while the next operation is
// taken; if that register is still full the controller waits before loading.
// Reset (synchronous, active low) stops all pumps, zeroes run times, clears
// the active pump, sets hours mode and working_mask to pump 0 only.
`timescale 1ns / 1ps

`include "duty_standby_pump_rotation_top_assert.svh"

module duty_standby_pump_rotation_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [15:0] elapsed_ms, [18:16] pump_index, [23:19] zero
    input  logic [dspr_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // [2:0] operation
    input  logic [dspr_pkg::OP_W-1:0]         i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [3:0] active_pump, [5:4] active_status, [6] station_fail, [7] start_failed
    output logic [dspr_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dspr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dspr_pkg::MASK_W-1:0]       i_cfg_data
);

    import dspr_pkg::*;

    t_fsm                   r_fsm, n_fsm;
    t_pstate                r_ps [PUMPS];
    t_pstate                n_ps [PUMPS];
    logic [PIDX_W-1:0]      r_act_idx, n_act_idx;
    logic                   r_act_valid, n_act_valid;
    logic                   r_mode;
    logic [MASK_W-1:0]      r_mask;
    logic [ELAPSED_W-1:0]   r_elapsed, n_elapsed;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic                   r_found, n_found;
    logic [PIDX_W-1:0]      r_best, n_best;
    logic [RUN_W-1:0]       r_best_time, n_best_time;
    logic                   r_sf, n_sf;
    logic                   r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data, n_out_data;

    logic [RUN_W-1:0]       mem [PUMPS];
    logic [RUN_W-1:0]       r_rd_data;
    logic [PIDX_W-1:0]      r_rd_addr;
    logic [PUMPS-1:0]       r_ent_vld;
    logic [PIDX_W-1:0]      rd_addr;
    logic                   mem_we;
    logic [RUN_W-1:0]       mem_wdata;

    logic [PUMPS-1:0]       working, elig, standby_ok;
    logic                   rr_found, fb_found, all_faulted, s_accept;
    logic [PIDX_W-1:0]      rr_idx, fb_idx;
    logic [RUN_W-1:0]       rd_value;
    logic [RUN_W:0]         tick_sum;
    logic [ELAPSED_W-1:0]   in_elapsed;
    logic [SEL_W-1:0]       in_sel;
    t_op                    in_op;

    assign in_elapsed = i_s_axis_tdata[ELAPSED_W-1:0];
    assign in_sel     = i_s_axis_tdata[ELAPSED_W +: SEL_W];
    assign in_op      = t_op'(i_s_axis_tuser);
    assign s_accept   = i_s_axis_tvalid && o_s_axis_tready;

    assign o_s_axis_tready = (r_fsm == FS_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_cfg_ready     = 1'b1;

    assign working  = PUMPS'(r_mask);
    assign rd_value = r_ent_vld[r_rd_addr] ? r_rd_data : '0;
    assign tick_sum = {1'b0, rd_value} + (RUN_W + 1)'(r_elapsed);

    always_comb begin
        for (int p = 0; p < PUMPS; p++) begin
            elig[p]       = working[p] && (r_ps[p] != PS_FAULTED);
            standby_ok[p] = !working[p] && (r_ps[p] != PS_FAULTED);
        end
    end

    // round-robin search and standby fallback
    always_comb begin
        logic [CNT_W:0]    sum;
        logic [PIDX_W-1:0] cand;
        rr_found = 1'b0;
        rr_idx   = '0;
        fb_found = 1'b0;
        fb_idx   = '0;
        all_faulted = 1'b1;
        for (int k = 1; k <= PUMPS; k++) begin
            sum = (CNT_W + 1)'(r_act_idx) + (CNT_W + 1)'(k);
            if (sum >= (CNT_W + 1)'(PUMPS)) begin
                sum = sum - (CNT_W + 1)'(PUMPS);
            end
            cand = r_act_valid ? PIDX_W'(sum) : PIDX_W'(k - 1);
            if (!rr_found && elig[cand]) begin
                rr_found = 1'b1;
                rr_idx   = cand;
            end
        end
        for (int p = 0; p < PUMPS; p++) begin
            if (!fb_found && standby_ok[p]) begin
                fb_found = 1'b1;
                fb_idx   = PIDX_W'(p);
            end
            if (r_ps[p] != PS_FAULTED) begin
                all_faulted = 1'b0;
            end
        end
    end

    always_comb begin
        logic              stopped_one;
        logic [PIDX_W-1:0] cand;
        n_fsm       = r_fsm;
        n_ps        = r_ps;
        n_act_idx   = r_act_idx;
        n_act_valid = r_act_valid;
        n_elapsed   = r_elapsed;
        n_idx       = r_idx;
        n_found     = r_found;
        n_best      = r_best;
        n_best_time = r_best_time;
        n_sf        = r_sf;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        rd_addr     = '0;
        mem_we      = 1'b0;
        mem_wdata   = tick_sum[RUN_W] ? RUN_MAX : tick_sum[RUN_W-1:0];
        stopped_one = 1'b0;
        cand        = PIDX_W'(r_idx - CNT_W'(1));
        case (r_fsm)
            FS_IDLE: begin
                if (s_accept) begin
                    n_sf  = 1'b0;
                    n_fsm = FS_FIN;
                    case (in_op)
                        OP_TICK: begin
                            n_elapsed = in_elapsed;
                            rd_addr   = r_act_idx;
                            if (r_act_valid && r_ps[r_act_idx] == PS_RUNNING) begin
                                n_fsm = FS_TICK;
                            end
                        end
                        OP_START: begin
                            if (r_mode) begin
                                n_found = rr_found;
                                n_best  = rr_idx;
                                n_fsm   = FS_PICK;
                            end else begin
                                n_found = 1'b0;
                                n_idx   = CNT_W'(1);
                                n_fsm   = FS_SCAN;
                            end
                        end
                        OP_STOP: begin
                            if (r_act_valid) begin
                                n_ps[r_act_idx] = PS_STOPPED;
                            end
                        end
                        OP_FRESET: begin
                            for (int p = 0; p < PUMPS; p++) begin
                                if (r_ps[p] == PS_FAULTED) begin
                                    n_ps[p] = PS_STOPPED;
                                end else if (!stopped_one && !working[p]
                                             && r_ps[p] == PS_RUNNING) begin
                                    n_ps[p]     = PS_STOPPED;
                                    stopped_one = 1'b1;
                                end
                            end
                        end
                        OP_FAULT: begin
                            if (32'(in_sel) < PUMPS) begin
                                n_ps[PIDX_W'(in_sel)] = PS_FAULTED;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            FS_TICK: begin
                mem_we = 1'b1;
                n_fsm  = FS_FIN;
            end
            FS_SCAN: begin
                if (elig[cand] && (!r_found || rd_value < r_best_time)) begin
                    n_found     = 1'b1;
                    n_best      = cand;
                    n_best_time = rd_value;
                end
                if (r_idx < CNT_W'(PUMPS)) begin
                    rd_addr = r_idx[PIDX_W-1:0];
                    n_idx   = r_idx + CNT_W'(1);
                end else begin
                    n_fsm = FS_PICK;
                end
            end
            FS_PICK: begin
                n_fsm = FS_FIN;
                if (r_found) begin
                    n_ps[r_best] = PS_RUNNING;
                    n_act_idx    = r_best;
                    n_act_valid  = 1'b1;
                end else if (fb_found) begin
                    n_ps[fb_idx] = PS_RUNNING;
                    n_act_idx    = fb_idx;
                    n_act_valid  = 1'b1;
                end else begin
                    n_sf = 1'b1;
                end
            end
            FS_FIN: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_sf, all_faulted,
                                   r_act_valid ? 2'(r_ps[r_act_idx]) : 2'(PS_STOPPED),
                                   r_act_valid ? ACT_W'(r_act_idx) : NONE_CODE};
                    n_fsm       = FS_IDLE;
                end
            end
            default: begin
                n_fsm = FS_IDLE;
            end
        endcase
    end

    // run-time RAM; a tick reads in its accept cycle and writes in the cycle after,
    // and no other operation is taken in between
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_act_idx] <= mem_wdata;
        end
        r_rd_data <= mem[rd_addr];
        r_rd_addr <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= FS_IDLE;
            for (int p = 0; p < PUMPS; p++) begin
                r_ps[p] <= PS_STOPPED;
            end
            r_ent_vld   <= '0;
            r_act_idx   <= '0;
            r_act_valid <= 1'b0;
            r_mode      <= 1'b0;
            r_mask      <= MASK_W'(1);
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_sf        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fsm       <= n_fsm;
            r_ps        <= n_ps;
            r_act_idx   <= n_act_idx;
            r_act_valid <= n_act_valid;
            r_idx       <= n_idx;
            r_found     <= n_found;
            r_sf        <= n_sf;
            r_out_valid <= n_out_valid;
            if (mem_we) begin
                r_ent_vld[r_act_idx] <= 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_ROT_MODE:  r_mode <= i_cfg_data[0];
                    CFG_WORK_MASK: r_mask <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_elapsed   <= n_elapsed;
        r_best      <= n_best;
        r_best_time <= n_best_time;
        r_out_data  <= n_out_data;
    end

    `DSPR_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, s_accept, !o_s_axis_tready)
    `DSPR_ASSERT_SAME(a_tick_needs_active, i_clk, i_rst_n, r_fsm == FS_TICK, r_act_valid)
    `DSPR_ASSERT_SAME(a_status_legal, i_clk, i_rst_n, r_out_valid,
                      r_out_data[5:4] != 2'd3)

endmodule
